>>> rtl/lbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg - shared types and constants for linear blend vertex skinning
// Fixed-point widths, request and status codes, and pipeline depths.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int MAX_JOINTS_DEF = 64;
	localparam int INFLUENCES_DEF = 4;
	localparam int WORDS          = 12;
	localparam int ROWS           = 3;
	localparam int COLS           = 4;

	localparam int W_W      = 16;   // Q0.16 weight
	localparam int JIDX_W   = 8;    // packed joint index
	localparam int WSUM_W   = 18;   // sum of up to four weights
	localparam int PW_W     = 48;   // weighted coordinate
	localparam int ACC_W    = 50;   // accumulated coordinate
	localparam int CNT_W    = 7;    // joint count register
	localparam int LIMIT_W  = 9;    // effective joint limit, at most 127

	localparam int QW         = 32;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = QW / DIV_STEP;

	localparam int XF_LAT   = 3;
	localparam int DIV_LAT  = 2 + DIV_STAGES;
	localparam int TAG_LAST = 1 + XF_LAT + 2 + DIV_LAT;

	localparam logic [CNT_W-1:0] JOINT_COUNT_RST = 7'd64;

	typedef logic signed [31:0] q16_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_SKIN  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_SKINNED = 2'd0,
		ST_PASS    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_WRITTEN = 2'd3
	} status_t;

	typedef struct packed {
		status_t           status;
		q16_t              px;
		q16_t              py;
		q16_t              pz;
		logic [WSUM_W-1:0] wsum;
	} tag_t;

endpackage

>>> rtl/lbs_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_mem - one bank of the matrix store
// One write port and one registered read port, one word per joint.
// ----------------------------------------------------------------------------
module lbs_mem #(
	parameter int DEPTH = lbs_pkg::MAX_JOINTS_DEF,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  lbs_pkg::q16_t     wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output lbs_pkg::q16_t     rdata
);

	lbs_pkg::q16_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/lbs_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_xform - per-influence affine transform and weighting
// Three stages: matrix products, rounded row sums with saturation, weighting.
// ----------------------------------------------------------------------------
module lbs_xform #(
	parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  lbs_pkg::q16_t                 mat [INFLUENCES][lbs_pkg::WORDS],
	input  lbs_pkg::q16_t                 px,
	input  lbs_pkg::q16_t                 py,
	input  lbs_pkg::q16_t                 pz,
	input  logic [lbs_pkg::W_W-1:0]       wt [INFLUENCES],
	output logic signed [lbs_pkg::PW_W-1:0] wp [INFLUENCES][lbs_pkg::ROWS]
);

	localparam int R = lbs_pkg::ROWS;

	lbs_pkg::q16_t           pos [3];
	logic signed [63:0]      prod_s2 [INFLUENCES][R][3];
	lbs_pkg::q16_t           trans_s2 [INFLUENCES][R];
	logic [lbs_pkg::W_W-1:0] wt_s2 [INFLUENCES];
	lbs_pkg::q16_t           pt_nx [INFLUENCES][R];
	lbs_pkg::q16_t           pt_s3 [INFLUENCES][R];
	logic [lbs_pkg::W_W-1:0] wt_s3 [INFLUENCES];

	assign pos[0] = px;
	assign pos[1] = py;
	assign pos[2] = pz;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < INFLUENCES; k++) begin
				for (int r = 0; r < R; r++) begin
					for (int c = 0; c < 3; c++) begin
						prod_s2[k][r][c] <= mat[k][r*lbs_pkg::COLS+c] * pos[c];
					end
					trans_s2[k][r] <= mat[k][r*lbs_pkg::COLS+3];
				end
				wt_s2[k] <= wt[k];
			end
		end
	end

	// Each product is rounded to Q16.16 before the row sum, then the point saturates.
	always_comb begin
		logic signed [63:0] rnd;
		logic signed [49:0] sum;
		rnd = '0;
		sum = '0;
		for (int k = 0; k < INFLUENCES; k++) begin
			for (int r = 0; r < R; r++) begin
				sum = 50'(trans_s2[k][r]);
				for (int c = 0; c < 3; c++) begin
					rnd = (prod_s2[k][r][c] + 64'sd32768) >>> 16;
					sum = sum + rnd[49:0];
				end
				if (sum > 50'sd2147483647) begin
					pt_nx[k][r] = 32'sh7fffffff;
				end else if (sum < -50'sd2147483648) begin
					pt_nx[k][r] = 32'sh80000000;
				end else begin
					pt_nx[k][r] = sum[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < INFLUENCES; k++) begin
				for (int r = 0; r < R; r++) begin
					pt_s3[k][r] <= pt_nx[k][r];
				end
				wt_s3[k] <= wt_s2[k];
			end
		end
	end

	// A zero-weight influence contributes nothing, whatever its matrix holds.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < INFLUENCES; k++) begin
				for (int r = 0; r < R; r++) begin
					if (wt_s3[k] == '0) begin
						wp[k][r] <= '0;
					end else begin
						wp[k][r] <= pt_s3[k][r] * $signed({1'b0, wt_s3[k]});
					end
				end
			end
		end
	end

endmodule

>>> rtl/lbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_div - pipelined rounding divider for one coordinate
// Adds half the divisor, flags quotients beyond 31 bits, then retires four
// quotient bits per stage by restoring division.
// ----------------------------------------------------------------------------
module lbs_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic [lbs_pkg::ACC_W-1:0]      mag,
	input  logic                           neg,
	input  logic [lbs_pkg::WSUM_W-1:0]     dvs,
	output logic [lbs_pkg::QW-1:0]         quo,
	output logic                           ovf,
	output logic                           neg_out
);

	localparam int DW = lbs_pkg::WSUM_W;
	localparam int QW = lbs_pkg::QW;
	localparam int NS = lbs_pkg::DIV_STAGES;
	localparam int NW = lbs_pkg::ACC_W;

	logic [NW-1:0] n_s7;
	logic [DW-1:0] d_s7;
	logic          neg_s7;

	logic [DW-1:0] r_s   [NS+1];
	logic [QW-1:0] nlo_s [NS+1];
	logic [QW-1:0] q_s   [NS+1];
	logic [DW-1:0] d_s   [NS+1];
	logic          ovf_s [NS+1];
	logic          neg_s [NS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			n_s7   <= mag + NW'(dvs >> 1);
			d_s7   <= dvs;
			neg_s7 <= neg;
		end
	end

	// The quotient fits in 31 bits exactly when the numerator is below d * 2^31.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= n_s7 >= {1'b0, d_s7, 31'b0};
			r_s[0]   <= n_s7[NW-1 -: DW];
			nlo_s[0] <= n_s7[QW-1:0];
			q_s[0]   <= '0;
			d_s[0]   <= d_s7;
			neg_s[0] <= neg_s7;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_step
		logic [DW-1:0] r_nx;
		logic [QW-1:0] n_nx;
		logic [QW-1:0] q_nx;

		always_comb begin
			logic [DW:0] rx;
			r_nx = r_s[g];
			n_nx = nlo_s[g];
			q_nx = q_s[g];
			rx   = '0;
			for (int b = 0; b < lbs_pkg::DIV_STEP; b++) begin
				rx   = {r_nx, n_nx[QW-1]};
				n_nx = {n_nx[QW-2:0], 1'b0};
				q_nx = {q_nx[QW-2:0], 1'b0};
				if (rx >= {1'b0, d_s[g]}) begin
					rx      = rx - {1'b0, d_s[g]};
					q_nx[0] = 1'b1;
				end
				r_nx = rx[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[g+1]   <= r_nx;
				nlo_s[g+1] <= n_nx;
				q_s[g+1]   <= q_nx;
				d_s[g+1]   <= d_s[g];
				ovf_s[g+1] <= ovf_s[g];
				neg_s[g+1] <= neg_s[g];
			end
		end
	end

	assign quo     = q_s[NS];
	assign ovf     = ovf_s[NS];
	assign neg_out = neg_s[NS];

endmodule

>>> rtl/linear_blend_vertex_skinning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning - four-influence skinning pipeline, Q16.16
// Stores 3x4 joint matrices and blends vertex positions by weighted joints.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_valid/in_ready. A write request (req_type 0) stores
// one matrix word; a skin request (req_type 1) transforms one vertex. Every
// request returns exactly one result on out_valid/out_ready, in order.
// The joint count register is written through cfg_we/cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce it.
// One request is taken every cycle unless the receiver stalls; the 16
// pipeline stages and the output register all advance together whenever
// the output register is empty or being taken. The matrix store is split
// into 12 word banks per influence, each read once per cycle, so all four
// joint matrices arrive in the same cycle. When the receiver stalls, the
// whole pipeline holds and in_ready is low. Reset clears valid bits and
// sets the joint count to 64; matrix contents are undefined until written.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning #(
	parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF,
	parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [5:0]          table_joint,
	input  logic [3:0]          table_word,
	input  logic signed [31:0]  table_value,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic [31:0]         joint_indices,
	input  logic [63:0]         influence_weights,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z,
	output logic [1:0]          status
);

	localparam int JW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int LAST = lbs_pkg::TAG_LAST;
	localparam int WS   = lbs_pkg::WSUM_W;
	localparam int LW   = lbs_pkg::LIMIT_W;

	logic [lbs_pkg::CNT_W-1:0] jcount_q;
	logic adv, accept, wr_en, rd_en;

	logic [LW-1:0]             limit;
	logic [lbs_pkg::W_W-1:0]   wt_in [INFLUENCES];
	logic [lbs_pkg::JIDX_W-1:0] jidx_in [INFLUENCES];
	logic [WS-1:0]             wsum_in;
	logic                      bad_in;
	lbs_pkg::tag_t             tag_in;

	logic [LAST:1]             vld_s;
	lbs_pkg::tag_t             tag_s [1:LAST];
	logic [lbs_pkg::W_W-1:0]   wt_s1 [INFLUENCES];
	lbs_pkg::q16_t             mat_s1 [INFLUENCES][lbs_pkg::WORDS];

	logic signed [lbs_pkg::PW_W-1:0]  wp_s4 [INFLUENCES][lbs_pkg::ROWS];
	logic signed [lbs_pkg::ACC_W-1:0] acc_nx [lbs_pkg::ROWS];
	logic signed [lbs_pkg::ACC_W-1:0] acc_s5 [lbs_pkg::ROWS];
	logic [lbs_pkg::ACC_W-1:0]        mag_s6 [lbs_pkg::ROWS];
	logic                             neg_s6 [lbs_pkg::ROWS];

	logic [lbs_pkg::QW-1:0] quo_d [lbs_pkg::ROWS];
	logic                   ovf_d [lbs_pkg::ROWS];
	logic                   neg_d [lbs_pkg::ROWS];
	lbs_pkg::q16_t          fin [lbs_pkg::ROWS];

	logic          out_valid_q;
	lbs_pkg::q16_t out_x_q, out_y_q, out_z_q;
	lbs_pkg::status_t status_q;

	// The whole pipeline moves whenever the output register can take a result.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jcount_q <= lbs_pkg::JOINT_COUNT_RST;
		end else if (cfg_we) begin
			jcount_q <= cfg_wdata;
		end
	end

	always_comb begin
		limit   = (LW'(jcount_q) > LW'(MAX_JOINTS)) ? LW'(MAX_JOINTS) : LW'(jcount_q);
		wsum_in = '0;
		bad_in  = 1'b0;
		for (int k = 0; k < INFLUENCES; k++) begin
			wt_in[k]   = influence_weights[lbs_pkg::W_W*k +: lbs_pkg::W_W];
			jidx_in[k] = joint_indices[lbs_pkg::JIDX_W*k +: lbs_pkg::JIDX_W];
			if (wt_in[k] != '0) begin
				wsum_in = wsum_in + WS'(wt_in[k]);
				if (LW'(jidx_in[k]) >= limit) begin
					bad_in = 1'b1;
				end
			end
		end
	end

	always_comb begin
		tag_in.px   = pos_x;
		tag_in.py   = pos_y;
		tag_in.pz   = pos_z;
		tag_in.wsum = wsum_in;
		priority if (req_type == lbs_pkg::REQ_WRITE) begin
			tag_in.status = lbs_pkg::ST_WRITTEN;
		end else if (bad_in) begin
			tag_in.status = lbs_pkg::ST_RANGE;
		end else if (wsum_in == '0) begin
			tag_in.status = lbs_pkg::ST_PASS;
		end else begin
			tag_in.status = lbs_pkg::ST_SKINNED;
		end
	end

	// Out-of-range words or joints are dropped but still answered.
	assign wr_en = accept && (req_type == lbs_pkg::REQ_WRITE)
		&& (table_word < 4'(lbs_pkg::WORDS)) && (LW'(table_joint) < LW'(MAX_JOINTS));
	assign rd_en = accept && (req_type == lbs_pkg::REQ_SKIN);

	logic [LW-1:0] wjoint;
	assign wjoint = LW'(table_joint);

	for (genvar k = 0; k < INFLUENCES; k++) begin : g_inf
		for (genvar wi = 0; wi < lbs_pkg::WORDS; wi++) begin : g_word
			lbs_mem #(
				.DEPTH (MAX_JOINTS),
				.AW    (JW)
			) u_mem (
				.clk   (clk),
				.we    (wr_en && (table_word == 4'(wi))),
				.waddr (wjoint[JW-1:0]),
				.wdata (table_value),
				.re    (rd_en),
				.raddr (jidx_in[k][JW-1:0]),
				.rdata (mat_s1[k][wi])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[1] <= tag_in;
			for (int i = 2; i <= LAST; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
			for (int k = 0; k < INFLUENCES; k++) begin
				wt_s1[k] <= wt_in[k];
			end
		end
	end

	lbs_xform #(
		.INFLUENCES (INFLUENCES)
	) u_xform (
		.clk (clk),
		.en  (adv),
		.mat (mat_s1),
		.px  (tag_s[1].px),
		.py  (tag_s[1].py),
		.pz  (tag_s[1].pz),
		.wt  (wt_s1),
		.wp  (wp_s4)
	);

	always_comb begin
		for (int r = 0; r < lbs_pkg::ROWS; r++) begin
			acc_nx[r] = '0;
			for (int k = 0; k < INFLUENCES; k++) begin
				acc_nx[r] = acc_nx[r] + lbs_pkg::ACC_W'(wp_s4[k][r]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < lbs_pkg::ROWS; r++) begin
				acc_s5[r] <= acc_nx[r];
				neg_s6[r] <= acc_s5[r][lbs_pkg::ACC_W-1];
				mag_s6[r] <= acc_s5[r][lbs_pkg::ACC_W-1] ? -acc_s5[r] : acc_s5[r];
			end
		end
	end

	for (genvar r = 0; r < lbs_pkg::ROWS; r++) begin : g_div
		lbs_div u_div (
			.clk     (clk),
			.en      (adv),
			.mag     (mag_s6[r]),
			.neg     (neg_s6[r]),
			.dvs     (tag_s[6].wsum),
			.quo     (quo_d[r]),
			.ovf     (ovf_d[r]),
			.neg_out (neg_d[r])
		);
	end

	always_comb begin
		for (int r = 0; r < lbs_pkg::ROWS; r++) begin
			if (ovf_d[r]) begin
				fin[r] = neg_d[r] ? 32'sh80000000 : 32'sh7fffffff;
			end else begin
				fin[r] = neg_d[r] ? -$signed(quo_d[r]) : $signed(quo_d[r]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= tag_s[LAST].status;
			unique case (tag_s[LAST].status)
				lbs_pkg::ST_SKINNED: begin
					out_x_q <= fin[0];
					out_y_q <= fin[1];
					out_z_q <= fin[2];
				end
				lbs_pkg::ST_PASS: begin
					out_x_q <= tag_s[LAST].px;
					out_y_q <= tag_s[LAST].py;
					out_z_q <= tag_s[LAST].pz;
				end
				default: begin
					out_x_q <= '0;
					out_y_q <= '0;
					out_z_q <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign status    = status_q;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted while the output is stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s[1])
		else $error("accepted request did not enter the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline valid bits moved during a stall");

	a_zero_results: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == lbs_pkg::ST_RANGE || status == lbs_pkg::ST_WRITTEN))
		|-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("error or write result carries a nonzero position");

endmodule

>>> test/tb_linear_blend_vertex_skinning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_blend_vertex_skinning - self-checking bench for the skinning block
// Loads joint matrices, skins random vertices under several joint counts and
// checks every result against a bit-exact predictor held in a scoreboard.
// ----------------------------------------------------------------------------
module tb_linear_blend_vertex_skinning;

	localparam int NJ        = 64;
	localparam int LATENCY   = 17;
	localparam int WDOG_MAX  = 2000;

	typedef struct {
		lbs_pkg::req_t kind;
		logic [5:0]  tj;
		logic [3:0]  tw;
		logic [31:0] tv;
		logic [31:0] px, py, pz;
		logic [31:0] jidx;
		logic [63:0] wts;
	} request_t;

	typedef struct {
		logic [31:0]      x, y, z;
		lbs_pkg::status_t st;
	} skin_result_t;

	class skin_scoreboard;
		logic signed [31:0] matrices [NJ*lbs_pkg::WORDS];
		logic [6:0]         jcount;
		skin_result_t       pending [$];
		int                 errors;

		function new();
			jcount = 7'd64;
			errors = 0;
		endfunction

		function automatic longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// Rounded Q16.16 product: add half an LSB, then floor.
		function automatic longint qmul(longint a, longint b);
			return (a * b + 64'sd32768) >>> 16;
		endfunction

		function void note_request(request_t r);
			skin_result_t e;
			longint pos [3];
			longint acc [3];
			longint wsum, w, p, q, mag;
			int lim, j, base;
			bit bad;
			e = '{x: 0, y: 0, z: 0, st: lbs_pkg::ST_WRITTEN};
			if (r.kind == lbs_pkg::REQ_WRITE) begin
				if (r.tw < lbs_pkg::WORDS) begin
					matrices[r.tj*lbs_pkg::WORDS + r.tw] = r.tv;
				end
				pending.insert(pending.size(), e);
				return;
			end
			pos[0] = $signed(r.px);
			pos[1] = $signed(r.py);
			pos[2] = $signed(r.pz);
			acc = '{0, 0, 0};
			wsum = 0;
			bad = 0;
			lim = (jcount > NJ) ? NJ : jcount;
			for (int k = 0; k < 4; k++) begin
				w = r.wts[16*k +: 16];
				j = r.jidx[8*k +: 8];
				if (w == 0) continue;
				if (j >= lim) begin
					bad = 1;
					continue;
				end
				base = j * lbs_pkg::WORDS;
				for (int row = 0; row < 3; row++) begin
					p = qmul(matrices[base+row*4], pos[0]) + qmul(matrices[base+row*4+1], pos[1])
						+ qmul(matrices[base+row*4+2], pos[2]) + longint'(matrices[base+row*4+3]);
					acc[row] += sat(p) * w;
				end
				wsum += w;
			end
			if (bad) begin
				e.st = lbs_pkg::ST_RANGE;
			end else if (wsum == 0) begin
				e = '{x: r.px, y: r.py, z: r.pz, st: lbs_pkg::ST_PASS};
			end else begin
				for (int row = 0; row < 3; row++) begin
					mag = (acc[row] < 0) ? -acc[row] : acc[row];
					q = (mag + wsum / 2) / wsum;
					q = sat((acc[row] < 0) ? -q : q);
					if (row == 0) e.x = q[31:0];
					else if (row == 1) e.y = q[31:0];
					else e.z = q[31:0];
				end
				e.st = lbs_pkg::ST_SKINNED;
			end
			pending.insert(pending.size(), e);
		endfunction

		function void check_result(skin_result_t a);
			skin_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with none expected: x=%h y=%h z=%h st=%0d",
					$time, a.x, a.y, a.z, a.st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, a.st);
				errors++;
			end
			if (a.x !== e.x) begin
				$display("%0t: out_x expected %h actual %h", $time, e.x, a.x);
				errors++;
			end
			if (a.y !== e.y) begin
				$display("%0t: out_y expected %h actual %h", $time, e.y, a.y);
				errors++;
			end
			if (a.z !== e.z) begin
				$display("%0t: out_z expected %h actual %h", $time, e.z, a.z);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [6:0]  cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        req_type = 0;
	logic [5:0]  table_joint = '0;
	logic [3:0]  table_word = '0;
	logic signed [31:0] table_value = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [31:0] joint_indices = '0;
	logic [63:0] influence_weights = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic signed [31:0] out_x, out_y, out_z;
	logic [1:0]  status;

	skin_scoreboard sb = new();
	int          idle_cycles = 0;
	bit          sink_on = 0;
	bit          quiet_phase = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	linear_blend_vertex_skinning DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.table_joint(table_joint), .table_word(table_word), .table_value(table_value),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .joint_indices(joint_indices),
		.influence_weights(influence_weights), .out_valid(out_valid),
		.out_ready(out_ready), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.status(status)
	);

	// Receiver: random stall before each result, checked at the accepting edge.
	always @(posedge clk) begin
		if (sink_on) begin
			if (out_valid && out_ready) begin
				sb.check_result('{x: out_x, y: out_y, z: out_z,
					st: lbs_pkg::status_t'(status)});
			end
		end
	end

	initial begin
		int gap;
		wait (sink_on);
		forever begin
			gap = quiet_phase ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Watchdog on cycles with no request or result taken.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("tb_linear_blend_vertex_skinning: errors");
			$finish;
		end
	end

	task automatic send(request_t r);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= r.kind;
		table_joint <= r.tj;
		table_word <= r.tw;
		table_value <= r.tv;
		pos_x <= r.px;
		pos_y <= r.py;
		pos_z <= r.pz;
		joint_indices <= r.jidx;
		influence_weights <= r.wts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic finish_phase();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_joint_count(logic [6:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.jcount = v;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0001_0000;
			default: return $urandom();
		endcase
	endfunction

	// Matrix entry biased toward modest scales so blends stay mostly unsaturated.
	function automatic logic [31:0] rand_entry();
		if ($urandom_range(0, 9) == 0) return rand_word();
		return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
	endfunction

	function automatic request_t write_req(int j, int w, logic [31:0] v);
		request_t r;
		r = '{kind: lbs_pkg::REQ_WRITE, tj: 6'(j), tw: 4'(w), tv: v, px: $urandom(),
			py: $urandom(), pz: $urandom(), jidx: $urandom(),
			wts: {$urandom(), $urandom()}};
		return r;
	endfunction

	function automatic request_t skin_req(logic [31:0] x, y, z, logic [31:0] ji,
			logic [63:0] wt);
		request_t r;
		r = '{kind: lbs_pkg::REQ_SKIN, tj: 6'($urandom()), tw: 4'($urandom()),
			tv: $urandom(), px: x, py: y, pz: z, jidx: ji, wts: wt};
		return r;
	endfunction

	// Skin request whose joint indices mostly lie below lim, so were written, and at times at or above it.
	function automatic request_t rand_skin(int lim);
		logic [31:0] ji;
		logic [63:0] wt;
		int m;
		for (int k = 0; k < 4; k++) begin
			m = $urandom_range(0, 9);
			wt[16*k +: 16] = 16'((m == 0) ? 0 : (m == 1) ? 32'hffff : $urandom());
			if ($urandom_range(0, 7) == 0)
				ji[8*k +: 8] = 8'($urandom_range(lim, 255));
			else
				ji[8*k +: 8] = 8'($urandom_range(0, lim - 1));
		end
		if ($urandom_range(0, 19) == 0) wt = '0;
		if ($urandom_range(0, 3) == 0)
			return skin_req(rand_word(), rand_word(), rand_word(), ji, wt);
		return skin_req($signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000,
			$signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000,
			$signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000, ji, wt);
	endfunction

	initial begin
		logic [6:0] counts [6];
		counts = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd17, 7'd65};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		sink_on = 1;

		// Fill every matrix, back to back, with no idling on either side.
		quiet_phase = 1;
		for (int j = 0; j < NJ; j++)
			for (int w = 0; w < lbs_pkg::WORDS; w++)
				send(write_req(j, w, rand_entry()));
		quiet_phase = 0;

		// Directed: identity on joint 0, extreme entries on joint 63, ignored words.
		for (int w = 0; w < lbs_pkg::WORDS; w++)
			send(write_req(0, w, (w % 5 == 0) ? 32'h0001_0000 : 32'h0));
		send(write_req(63, 0, 32'h7fff_ffff));
		send(write_req(63, 5, 32'h8000_0000));
		send(write_req(63, 3, 32'h7fff_ffff));
		send(write_req(5, 12, 32'hdead_beef));
		send(write_req(5, 15, 32'h1234_5678));
		send(skin_req(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 64'h0000_0000_0000_ffff));
		send(skin_req(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h3f3f_3f3f,
			64'hffff_ffff_ffff_ffff));
		send(skin_req(32'h1234_5678, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 64'h0));
		send(skin_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_ff00,
			64'h0000_0000_0000_8000));
		send(skin_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_ff00,
			64'h0000_0000_0001_8000));
		send(skin_req(32'h0, 32'h0, 32'h0, 32'h3f00_3f00, 64'h0001_0000_0001_0001));
		finish_phase();

		foreach (counts[c]) begin
			int lim;
			set_joint_count(counts[c]);
			lim = (counts[c] == 0) ? 1 : (counts[c] > NJ ? NJ : counts[c]);
			send(skin_req($urandom(), $urandom(), $urandom(), 32'h0000_0000,
				64'h0000_0000_0000_0001));
			for (int i = 0; i < 184; i++) begin
				if ($urandom_range(0, 9) == 0)
					send(write_req($urandom_range(0, 63), $urandom_range(0, 15), rand_entry()));
				else
					send(rand_skin(lim));
			end
			finish_phase();
		end

		if (sb.pending.size() != 0 || sb.errors != 0)
			$display("tb_linear_blend_vertex_skinning: errors");
		else
			$display("tb_linear_blend_vertex_skinning: clean");
		$finish;
	end
endmodule

>>> files.f
rtl/lbs_pkg.sv
rtl/lbs_mem.sv
rtl/lbs_xform.sv
rtl/lbs_div.sv
rtl/linear_blend_vertex_skinning.sv
test/tb_linear_blend_vertex_skinning.sv
